// ----- src/bbm_pkg.sv -----
package bbm_pkg;

   localparam int BASE_ADDRESS_BITS = 13;
   localparam int BEAT_BITS         = 3;
   localparam int BEATS             = 2 ** BEAT_BITS;
   localparam int BYTE_BITS         = 8;
   localparam int BYTE_SEL_BITS     = BEAT_BITS + 3;
   localparam int WORD_BITS         = BEATS * BYTE_BITS;
   localparam int ADDR_BITS         = 16;

   typedef enum logic [1:0] {
      LINE_LOW      = 2'd0,
      LINE_HIGH     = 2'd1,
      LINE_RELEASED = 2'd2
   } line_type;

   typedef enum logic [2:0] {
      PH_IDLE         = 3'd0,
      PH_WAIT_GRANT   = 3'd1,
      PH_DRIVE        = 3'd2,
      PH_HOLD         = 3'd3,
      PH_GAP          = 3'd4,
      PH_WAIT_RELEASE = 3'd5
   } phase_type;

   typedef struct packed {
      logic                         start_req;
      logic                         is_read;
      logic [BASE_ADDRESS_BITS-1:0] base_address;
      logic [WORD_BITS-1:0]         write_word;
      logic                         bus_grant;
      logic                         mem_ready;
      logic [BYTE_BITS-1:0]         mem_read_data;
   } req_type;

   typedef struct packed {
      line_type             bus_request;
      logic [ADDR_BITS-1:0] mem_address;
      logic                 address_driven;
      logic [BYTE_BITS-1:0] mem_write_data;
      logic                 data_driven;
      line_type             chip_select;
      line_type             read_not_write;
      logic                 busy_res;
      logic                 done_res;
      logic [WORD_BITS-1:0] read_word;
   } rsp_type;

endpackage

// ----- src/bbm_core.sv -----
module bbm_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  bbm_pkg::req_type req,
   output bbm_pkg::rsp_type rsp
);

   bbm_pkg::phase_type                          phase_ff, phase_in;
   logic [bbm_pkg::BEAT_BITS-1:0]               beat_ff, beat_in;
   logic [bbm_pkg::BASE_ADDRESS_BITS-1:0]       base_ff, base_in;
   logic [bbm_pkg::WORD_BITS-1:0]               data_ff, data_in;
   logic                                        dir_read_ff, dir_read_in;
   logic                                        last_grant_ff, last_ready_ff;
   bbm_pkg::line_type                           request_ff, request_in;

   logic                                        grant_rise, grant_fall;
   logic                                        ready_rise, ready_fall;
   logic                                        done;
   logic                                        drv;
   logic [bbm_pkg::BYTE_SEL_BITS-1:0]           sel_now, sel_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= bbm_pkg::PH_IDLE;
         beat_ff       <= '0;
         base_ff       <= '0;
         data_ff       <= '0;
         dir_read_ff   <= 1'b0;
         last_grant_ff <= 1'b0;
         last_ready_ff <= 1'b0;
         request_ff    <= bbm_pkg::LINE_RELEASED;
      end else if (step) begin
         phase_ff      <= phase_in;
         beat_ff       <= beat_in;
         base_ff       <= base_in;
         data_ff       <= data_in;
         dir_read_ff   <= dir_read_in;
         last_grant_ff <= req.bus_grant;
         last_ready_ff <= req.mem_ready;
         request_ff    <= request_in;
      end
   end

   assign grant_rise = req.bus_grant & ~last_grant_ff;
   assign grant_fall = ~req.bus_grant & last_grant_ff;
   assign ready_rise = req.mem_ready & ~last_ready_ff;
   assign ready_fall = ~req.mem_ready & last_ready_ff;
   assign sel_now    = {beat_ff, 3'b000};

   always_comb begin
      phase_in    = phase_ff;
      beat_in     = beat_ff;
      base_in     = base_ff;
      data_in     = data_ff;
      dir_read_in = dir_read_ff;
      request_in  = request_ff;
      done        = 1'b0;
      case (phase_ff)
         bbm_pkg::PH_IDLE: begin
            if (req.start_req) begin
               base_in     = req.base_address;
               dir_read_in = req.is_read;
               data_in     = req.is_read ? '0 : req.write_word;
               beat_in     = '0;
               request_in  = bbm_pkg::LINE_HIGH;
               phase_in    = bbm_pkg::PH_WAIT_GRANT;
            end
         end
         bbm_pkg::PH_WAIT_GRANT: begin
            if (grant_rise) begin
               beat_in  = '0;
               phase_in = bbm_pkg::PH_DRIVE;
            end
         end
         bbm_pkg::PH_DRIVE: begin
            if (ready_rise) begin
               if (dir_read_ff) begin
                  data_in[sel_now +: bbm_pkg::BYTE_BITS] = req.mem_read_data;
               end
               phase_in = bbm_pkg::PH_HOLD;
            end
         end
         bbm_pkg::PH_HOLD: begin
            if (ready_fall) begin
               phase_in = bbm_pkg::PH_GAP;
            end
         end
         bbm_pkg::PH_GAP: begin
            if (beat_ff == bbm_pkg::BEAT_BITS'(bbm_pkg::BEATS - 1)) begin
               request_in = bbm_pkg::LINE_LOW;
               phase_in   = bbm_pkg::PH_WAIT_RELEASE;
            end else begin
               beat_in  = beat_ff + 1'b1;
               phase_in = bbm_pkg::PH_DRIVE;
            end
         end
         bbm_pkg::PH_WAIT_RELEASE: begin
            if (grant_fall) begin
               request_in = bbm_pkg::LINE_RELEASED;
               phase_in   = bbm_pkg::PH_IDLE;
               done       = 1'b1;
            end
         end
         default: begin
            phase_in = bbm_pkg::PH_IDLE;
         end
      endcase
   end

   // Result lines reflect the state after this sample's update.
   assign drv      = (phase_in == bbm_pkg::PH_DRIVE) || (phase_in == bbm_pkg::PH_HOLD);
   assign sel_next = {beat_in, 3'b000};

   always_comb begin
      rsp.bus_request    = request_in;
      rsp.mem_address    = drv ? bbm_pkg::ADDR_BITS'({base_in, beat_in}) : '0;
      rsp.address_driven = drv;
      rsp.mem_write_data = (drv && !dir_read_in) ? data_in[sel_next +: bbm_pkg::BYTE_BITS]
                                                 : '0;
      rsp.data_driven    = drv && !dir_read_in;
      rsp.chip_select    = (phase_in == bbm_pkg::PH_DRIVE) ? bbm_pkg::LINE_HIGH :
                           (phase_in == bbm_pkg::PH_HOLD)  ? bbm_pkg::LINE_LOW  :
                                                             bbm_pkg::LINE_RELEASED;
      rsp.read_not_write = !drv        ? bbm_pkg::LINE_RELEASED :
                           dir_read_in ? bbm_pkg::LINE_HIGH : bbm_pkg::LINE_LOW;
      rsp.busy_res       = (phase_in != bbm_pkg::PH_IDLE);
      rsp.done_res       = done;
      rsp.read_word      = (done && dir_read_ff) ? data_ff : '0;
   end

endmodule

// ----- src/burst_bus_master_unit.sv -----
// Burst bus master: moves one 64-bit word as eight byte beats over a
// request/grant bus and a ready-handshaked memory port.
//
// Input channel (req_*): each beat is one sampled bus cycle: start request,
// direction, base address, write word, grant, memory ready and read byte.
// Result channel (rsp_*): one beat per input beat, carrying the bus and
// memory lines as they stand after that sample, busy, a done pulse and,
// on the done beat of a read burst, the assembled read word.
//
// Throughput is one beat per cycle while the receiver does not stall. An accepted
// beat lands in the input register, the controller then updates its state and
// writes the result register, and rsp_valid rises with that write.
// The controller state advances only when a beat moves from the input
// register into the result register, so stalls never skip or repeat a sample.
//
// Reset (synchronous, active high) empties both registers and puts the
// controller in idle with the request line released. When the receiver
// stalls, the result register holds, the input register fills, and then
// req_ready drops until rsp_ready returns.
module burst_bus_master_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_start_req,
   input  logic                                  req_is_read,
   input  logic [bbm_pkg::BASE_ADDRESS_BITS-1:0] req_base_address,
   input  logic [bbm_pkg::WORD_BITS-1:0]         req_write_word,
   input  logic                                  req_bus_grant,
   input  logic                                  req_mem_ready,
   input  logic [bbm_pkg::BYTE_BITS-1:0]         req_mem_read_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_bus_request,
   output logic [bbm_pkg::ADDR_BITS-1:0]         rsp_mem_address,
   output logic                                  rsp_address_driven,
   output logic [bbm_pkg::BYTE_BITS-1:0]         rsp_mem_write_data,
   output logic                                  rsp_data_driven,
   output logic [1:0]                            rsp_chip_select,
   output logic [1:0]                            rsp_read_not_write,
   output logic                                  rsp_busy_res,
   output logic                                  rsp_done_res,
   output logic [bbm_pkg::WORD_BITS-1:0]         rsp_read_word
);

   logic             in_valid_ff, in_valid_in;
   bbm_pkg::req_type in_data_ff;
   logic             out_valid_ff, out_valid_in;
   bbm_pkg::rsp_type out_data_ff;
   bbm_pkg::rsp_type core_rsp;
   bbm_pkg::req_type req_beat;
   logic             advance;
   logic             take;

   // Advance the held sample when the result register is free or draining.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign req_beat.start_req     = req_start_req;
   assign req_beat.is_read       = req_is_read;
   assign req_beat.base_address  = req_base_address;
   assign req_beat.write_word    = req_write_word;
   assign req_beat.bus_grant     = req_bus_grant;
   assign req_beat.mem_ready     = req_mem_ready;
   assign req_beat.mem_read_data = req_mem_read_data;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on their own handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (take) begin
         in_data_ff <= req_beat;
      end
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   bbm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .rsp   (core_rsp)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_bus_request    = out_data_ff.bus_request;
   assign rsp_mem_address    = out_data_ff.mem_address;
   assign rsp_address_driven = out_data_ff.address_driven;
   assign rsp_mem_write_data = out_data_ff.mem_write_data;
   assign rsp_data_driven    = out_data_ff.data_driven;
   assign rsp_chip_select    = out_data_ff.chip_select;
   assign rsp_read_not_write = out_data_ff.read_not_write;
   assign rsp_busy_res       = out_data_ff.busy_res;
   assign rsp_done_res       = out_data_ff.done_res;
   assign rsp_read_word      = out_data_ff.read_word;

endmodule

// ----- verif/burst_bus_master_unit_tb.sv -----
`timescale 1ns / 100ps

module burst_bus_master_unit_tb;
   import bbm_pkg::*;

   // Run shape: number of input beats, where the sender waits for the
   // result queue to drain, and the window with no idling on either side.
   localparam int ITEM_TOTAL   = 1250;
   localparam int PLAN_ROWS    = 15;
   localparam int DRAIN_AT     = 900;
   localparam int STEADY_LO    = 500;
   localparam int STEADY_HI    = 750;
   localparam int IDLE_PCT     = 34;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         req_valid         = 1'b0;
   logic                         req_ready;
   logic                         req_start_req     = 1'b0;
   logic                         req_is_read       = 1'b0;
   logic [BASE_ADDRESS_BITS-1:0] req_base_address  = '0;
   logic [WORD_BITS-1:0]         req_write_word    = '0;
   logic                         req_bus_grant     = 1'b0;
   logic                         req_mem_ready     = 1'b0;
   logic [BYTE_BITS-1:0]         req_mem_read_data = '0;
   logic                         rsp_valid;
   logic                         rsp_ready         = 1'b0;
   logic [1:0]                   rsp_bus_request;
   logic [ADDR_BITS-1:0]         rsp_mem_address;
   logic                         rsp_address_driven;
   logic [BYTE_BITS-1:0]         rsp_mem_write_data;
   logic                         rsp_data_driven;
   logic [1:0]                   rsp_chip_select;
   logic [1:0]                   rsp_read_not_write;
   logic                         rsp_busy_res;
   logic                         rsp_done_res;
   logic [WORD_BITS-1:0]         rsp_read_word;

   // Predicted master state, advanced once per accepted beat.
   phase_type                    burst_phase;
   logic [BEAT_BITS-1:0]         beat_no;
   logic [BASE_ADDRESS_BITS-1:0] addr_base;
   logic [WORD_BITS-1:0]         word_buf;
   logic                         reading;
   logic                         grant_was;
   logic                         ready_was;
   line_type                     req_line;

   rsp_type expected_lines[$];
   req_type cur_item;
   logic    cur_typed;
   rsp_type cur_want;
   int      items_taken    = 0;
   int      mismatch_count = 0;
   int      stall_cycles   = 0;
   logic    steady_phase;

   assign steady_phase = (items_taken >= STEADY_LO) && (items_taken < STEADY_HI);

   always #4 clock = ~clock;

   burst_bus_master_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_start_req      (req_start_req),
      .req_is_read        (req_is_read),
      .req_base_address   (req_base_address),
      .req_write_word     (req_write_word),
      .req_bus_grant      (req_bus_grant),
      .req_mem_ready      (req_mem_ready),
      .req_mem_read_data  (req_mem_read_data),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bus_request    (rsp_bus_request),
      .rsp_mem_address    (rsp_mem_address),
      .rsp_address_driven (rsp_address_driven),
      .rsp_mem_write_data (rsp_mem_write_data),
      .rsp_data_driven    (rsp_data_driven),
      .rsp_chip_select    (rsp_chip_select),
      .rsp_read_not_write (rsp_read_not_write),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_read_word      (rsp_read_word)
   );

   // ------------------------------------------------------------------
   // Master predictor
   // ------------------------------------------------------------------

   task automatic restart_master();
      burst_phase = PH_IDLE;
      beat_no     = '0;
      addr_base   = '0;
      word_buf    = '0;
      reading     = 1'b0;
      grant_was   = 1'b0;
      ready_was   = 1'b0;
      req_line    = LINE_RELEASED;
   endtask

   // Step the master by one sampled bus cycle and return the lines as they
   // stand after that cycle.
   task automatic advance_master(input req_type s, output rsp_type r);
      logic grant_up;
      logic grant_dn;
      logic ready_up;
      logic ready_dn;
      logic drv;
      grant_up = s.bus_grant && !grant_was;
      grant_dn = !s.bus_grant && grant_was;
      ready_up = s.mem_ready && !ready_was;
      ready_dn = !s.mem_ready && ready_was;
      r = '0;

      case (burst_phase)
         PH_IDLE: begin
            if (s.start_req) begin
               addr_base   = s.base_address;
               reading     = s.is_read;
               word_buf    = s.is_read ? '0 : s.write_word;
               beat_no     = '0;
               req_line    = LINE_HIGH;
               burst_phase = PH_WAIT_GRANT;
            end
         end
         PH_WAIT_GRANT: begin
            if (grant_up) begin
               beat_no     = '0;
               burst_phase = PH_DRIVE;
            end
         end
         PH_DRIVE: begin
            if (ready_up) begin
               if (reading)
                  word_buf[{beat_no, 3'b000} +: BYTE_BITS] = s.mem_read_data;
               burst_phase = PH_HOLD;
            end
         end
         PH_HOLD: begin
            if (ready_dn)
               burst_phase = PH_GAP;
         end
         PH_GAP: begin
            if (beat_no == BEAT_BITS'(BEATS - 1)) begin
               req_line    = LINE_LOW;
               burst_phase = PH_WAIT_RELEASE;
            end else begin
               beat_no     = beat_no + 1'b1;
               burst_phase = PH_DRIVE;
            end
         end
         PH_WAIT_RELEASE: begin
            if (grant_dn) begin
               req_line    = LINE_RELEASED;
               burst_phase = PH_IDLE;
               r.done_res  = 1'b1;
               r.read_word = reading ? word_buf : '0;
            end
         end
         default: burst_phase = PH_IDLE;
      endcase

      grant_was = s.bus_grant;
      ready_was = s.mem_ready;

      drv              = (burst_phase == PH_DRIVE) || (burst_phase == PH_HOLD);
      r.bus_request    = req_line;
      r.mem_address    = drv ? {addr_base, beat_no} : '0;
      r.address_driven = drv;
      r.mem_write_data = (drv && !reading) ? word_buf[{beat_no, 3'b000} +: BYTE_BITS] : '0;
      r.data_driven    = drv && !reading;
      r.chip_select    = (burst_phase == PH_DRIVE) ? LINE_HIGH :
                         (burst_phase == PH_HOLD)  ? LINE_LOW  : LINE_RELEASED;
      r.read_not_write = !drv ? LINE_RELEASED : (reading ? LINE_HIGH : LINE_LOW);
      r.busy_res       = (burst_phase != PH_IDLE);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Directed opening: idle noise, a read burst at the top base address
   // whose grant rises in the start cycle, a start while busy, a ready fall
   // before any ready rise, a held ready, and the first two byte beats.
   // Random beats pick up the burst wherever this table leaves it.
   // Field order: start, read, base, word, grant, ready, read byte.
   task automatic plan_row(input int k, output req_type s, output logic typed,
                           output rsp_type w);
      typed = 1'b0;
      w     = '0;
      case (k)
         0:  s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b0, 1'b0, 8'h00};
         1:  s = {1'b0, 1'b1, 13'h1FFF, {64{1'b1}}, 1'b1, 1'b1, 8'hFF};
         2:  s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b0, 1'b0, 8'h00};
         3:  s = {1'b1, 1'b1, 13'h1FFF, {64{1'b1}}, 1'b1, 1'b0, 8'h00};
         4:  s = {1'b1, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b0, 8'h00};
         5:  s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b0, 1'b0, 8'h00};
         6:  s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b1, 8'h00};
         7:  s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b0, 8'h00};
         8:  s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b1, 8'hFF};
         9:  s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b1, 8'h00};
         10: s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b0, 8'h00};
         11: s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b0, 8'h00};
         12: s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b1, 8'h00};
         13: s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b0, 8'hFF};
         default: s = {1'b0, 1'b0, 13'h0000, 64'h0, 1'b1, 1'b0, 8'h00};
      endcase
      // Idle rows: every line released, nothing busy.
      if (k <= 2) begin
         typed            = 1'b1;
         w.bus_request    = LINE_RELEASED;
         w.chip_select    = LINE_RELEASED;
         w.read_not_write = LINE_RELEASED;
      end
      // Grant rise: first read beat at the top address, chip select high.
      if (k == 6) begin
         typed            = 1'b1;
         w.bus_request    = LINE_HIGH;
         w.mem_address    = 16'hFFF8;
         w.address_driven = 1'b1;
         w.chip_select    = LINE_HIGH;
         w.read_not_write = LINE_HIGH;
         w.busy_res       = 1'b1;
      end
   endtask

   // Random beat. Most beats play a well-behaved arbiter and memory that
   // move the burst along from the predicted phase; the rest are noise.
   task automatic make_item(output req_type s);
      int mode;
      mode = $urandom_range(99);
      s.start_req = ($urandom_range(7) == 0);
      s.is_read   = 1'($urandom_range(1));
      case ($urandom_range(7))
         0:       s.base_address = '0;
         1:       s.base_address = '1;
         default: s.base_address =
                     BASE_ADDRESS_BITS'($urandom_range((1 << BASE_ADDRESS_BITS) - 1));
      endcase
      case ($urandom_range(7))
         0:       s.write_word = '0;
         1:       s.write_word = '1;
         default: s.write_word = {$urandom, $urandom};
      endcase
      case ($urandom_range(7))
         0:       s.mem_read_data = 8'h00;
         1:       s.mem_read_data = 8'hFF;
         default: s.mem_read_data = BYTE_BITS'($urandom_range(255));
      endcase
      s.bus_grant = grant_was;
      s.mem_ready = ready_was;

      if (mode < 10) begin
         s.start_req = 1'($urandom_range(1));
         s.bus_grant = 1'($urandom_range(1));
         s.mem_ready = 1'($urandom_range(1));
      end else begin
         case (burst_phase)
            PH_IDLE: begin
               s.start_req = ($urandom_range(2) == 0);
               s.bus_grant = 1'($urandom_range(1));
               s.mem_ready = 1'($urandom_range(1));
            end
            // Drop a stale high line first so that a rising edge can follow.
            PH_WAIT_GRANT:   s.bus_grant = grant_was ? 1'b0 : 1'($urandom_range(1));
            PH_DRIVE:        s.mem_ready = ready_was ? 1'b0 : 1'($urandom_range(1));
            PH_HOLD:         s.mem_ready = 1'($urandom_range(1));
            PH_WAIT_RELEASE: s.bus_grant = grant_was ? 1'($urandom_range(1)) : 1'b1;
            default: ;
         endcase
      end
   endtask

   // Sender: on acceptance, advance the predictor and queue the expected
   // beat; then offer the next beat unless idling or draining. Hold valid
   // and payload until the beat is taken.
   always @(posedge clock) begin : send_proc
      rsp_type line_now;
      logic    offer_now;
      if (reset) begin
         restart_master();
         req_valid <= 1'b0;
      end else begin
         offer_now = req_valid;
         if (req_valid && req_ready) begin
            advance_master(cur_item, line_now);
            expected_lines.push_back(cur_typed ? cur_want : line_now);
            items_taken++;
            offer_now = 1'b0;
         end
         if (!offer_now && items_taken < ITEM_TOTAL
             && !(items_taken == DRAIN_AT && expected_lines.size() != 0)
             && (steady_phase || $urandom_range(99) >= IDLE_PCT)) begin
            if (items_taken < PLAN_ROWS) begin
               plan_row(items_taken, cur_item, cur_typed, cur_want);
            end else begin
               make_item(cur_item);
               cur_typed = 1'b0;
            end
            offer_now = 1'b1;
         end
         req_valid         <= offer_now;
         req_start_req     <= cur_item.start_req;
         req_is_read       <= cur_item.is_read;
         req_base_address  <= cur_item.base_address;
         req_write_word    <= cur_item.write_word;
         req_bus_grant     <= cur_item.bus_grant;
         req_mem_ready     <= cur_item.mem_ready;
         req_mem_read_data <= cur_item.mem_read_data;
      end
   end

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("%0t: MISMATCH %s got %h want %h", $realtime, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // Receiver: compare each result beat with the oldest expectation.
   always @(posedge clock) begin : take_proc
      rsp_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_lines.size() == 0) begin
               report_mismatch("result beat with nothing expected", '0, '0);
            end else begin
               w = expected_lines.pop_front();
               compare_field("bus_request",    64'(rsp_bus_request),    64'(w.bus_request));
               compare_field("mem_address",    64'(rsp_mem_address),    64'(w.mem_address));
               compare_field("address_driven", 64'(rsp_address_driven),
                             64'(w.address_driven));
               compare_field("mem_write_data", 64'(rsp_mem_write_data),
                             64'(w.mem_write_data));
               compare_field("data_driven",    64'(rsp_data_driven),    64'(w.data_driven));
               compare_field("chip_select",    64'(rsp_chip_select),    64'(w.chip_select));
               compare_field("read_not_write", 64'(rsp_read_not_write),
                             64'(w.read_not_write));
               compare_field("busy_res",       64'(rsp_busy_res),       64'(w.busy_res));
               compare_field("done_res",       64'(rsp_done_res),       64'(w.done_res));
               compare_field("read_word",      rsp_read_word,           w.read_word);
            end
         end
         rsp_ready <= steady_phase || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: end the run if neither channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Reset once, then wait for every beat to be sent and answered, let the
   // pipeline settle, and report.
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (!(items_taken == ITEM_TOTAL && expected_lines.size() == 0))
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/bbm_pkg.sv
src/bbm_core.sv
src/burst_bus_master_unit.sv
verif/burst_bus_master_unit_tb.sv
